// File: design/ptb_pkg.sv
// shared types and constants for the periodic timer bank
`timescale 1ns / 1ps

package ptb_pkg;

  // most expiries reported for one tick
  localparam int MAX_RESULTS = 8;
  localparam int RW = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_STOP  = 2'd2;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // what the engine hands to the output stage
  typedef enum logic [1:0] {
    PUSH_ACK  = 2'd0,
    PUSH_EXP  = 2'd1,
    PUSH_DONE = 2'd2
  } push_kind_t;

  typedef struct packed {
    logic       vld;
    push_kind_t kind;
    logic [7:0] slot;
    logic       status;
  } push_t;

  // one memory word per slot
  typedef struct packed {
    logic [7:0] period;
    logic [7:0] count;
  } slot_word_t;

endpackage

// File: design/ptb_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module ptb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/ptb_emit.sv
// output stage: holds the latest expiry until the next one shows whether it is last
`timescale 1ns / 1ps

module ptb_emit (
  input  logic          clk,
  input  logic          rst,
  input  ptb_pkg::push_t push,
  output logic          push_ready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [15:0]   m_tdata,   // slot_out[7:0], status[8], zero pad
  output logic          m_tuser,   // event_kind
  output logic          m_tlast
);
  import ptb_pkg::*;

  logic       out_vld;
  logic [7:0] out_slot;
  logic       out_status;
  logic       out_kind;
  logic       out_last;
  logic       pend_vld;
  logic [7:0] pend_slot;
  logic       out_free;
  logic       load;

  assign out_free = !out_vld || m_tready;

  always_comb begin
    case (push.kind)
      PUSH_ACK:  push_ready = out_free;
      PUSH_EXP:  push_ready = !pend_vld || out_free;
      PUSH_DONE: push_ready = !pend_vld || out_free;
      default:   push_ready = 1'b1;
    endcase
  end

  // an ack always loads; expiry and done load only when a pending expiry exists
  assign load = push.vld && push_ready &&
                (push.kind == PUSH_ACK || pend_vld);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      pend_vld <= 1'b0;
    end else begin
      if (load) begin
        out_vld <= 1'b1;
      end else if (m_tready) begin
        out_vld <= 1'b0;
      end
      if (push.vld && push_ready) begin
        if (push.kind == PUSH_EXP) begin
          pend_vld <= 1'b1;
        end else if (push.kind == PUSH_DONE) begin
          pend_vld <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld && push_ready && push.kind == PUSH_EXP) begin
      pend_slot <= push.slot;
    end
    if (load) begin
      if (push.kind == PUSH_ACK) begin
        out_kind   <= KIND_ACK;
        out_slot   <= push.slot;
        out_status <= push.status;
        out_last   <= 1'b1;
      end else begin
        out_kind   <= KIND_EXPIRY;
        out_slot   <= pend_slot;
        out_status <= STATUS_OK;
        out_last   <= (push.kind == PUSH_DONE);
      end
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {7'd0, out_status, out_slot};
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;

endmodule

// File: design/ptb_engine.sv
// request decode and slot walk: read-modify-write of the slot memory
`timescale 1ns / 1ps

module ptb_engine #(
  parameter int NUM_SLOTS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [15:0]   s_tdata,
  input  logic [1:0]    s_tuser,
  output logic          we,
  output logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] waddr,
  output logic [15:0]   wdata,
  output logic          re,
  output logic [(NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1)-1:0] raddr,
  input  logic [15:0]   rdata,
  output ptb_pkg::push_t push,
  input  logic          push_ready
);
  import ptb_pkg::*;

  localparam int AW = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
  localparam int PW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_DONE = 4'b0100,
    ST_ACK  = 4'b1000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [NUM_SLOTS-1:0] valid;
  logic [PW-1:0]    rd_ptr;
  logic             chk_vld;
  logic [AW-1:0]    chk_slot;
  logic [RW-1:0]    nrep;
  logic [7:0]       ack_slot;
  logic             ack_err;

  logic       accept;
  logic [7:0] req_idx;
  logic [7:0] req_per;
  logic       req_err;
  logic       is_setup;
  slot_word_t cur;
  logic       en;
  logic [7:0] cnt1;
  logic       exp_hit;
  logic       report;
  logic       advance;
  logic       more;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign req_idx  = s_tdata[7:0];
  assign req_per  = s_tdata[15:8];
  assign req_err  = (req_idx >= 8'(NUM_SLOTS));
  assign is_setup = (s_tuser == REQ_START) || (s_tuser == REQ_STOP);

  // a slot never started reads as disabled
  assign cur     = slot_word_t'(rdata);
  assign en      = valid[chk_slot] && (cur.period != 8'd0);
  assign cnt1    = cur.count + 8'd1;
  assign exp_hit = en && (cnt1 == cur.period);
  assign report  = chk_vld && exp_hit && (nrep != RW'(MAX_RESULTS));
  assign advance = !report || push_ready;
  assign more    = (rd_ptr != PW'(NUM_SLOTS));

  always_comb begin
    we    = 1'b0;
    waddr = chk_slot;
    wdata = {cur.period, (exp_hit ? 8'd0 : cnt1)};
    re    = 1'b0;
    raddr = rd_ptr[AW-1:0];
    push  = '{vld: 1'b0, kind: PUSH_EXP, slot: 8'(chk_slot), status: STATUS_OK};
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && is_setup) begin
          we    = !req_err;
          waddr = req_idx[AW-1:0];
          wdata = {(s_tuser == REQ_START ? req_per : 8'd0), 8'd0};
          state_next = ST_ACK;
        end else if (accept && s_tuser == REQ_TICK) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        push.vld = report;
        we = chk_vld && en && advance;
        re = advance && more;
        if (advance && !more) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        push.vld  = 1'b1;
        push.kind = PUSH_DONE;
        if (push_ready) begin
          state_next = ST_IDLE;
        end
      end
      ST_ACK: begin
        push = '{vld: 1'b1, kind: PUSH_ACK, slot: ack_slot, status: ack_err};
        if (push_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      valid   <= '0;
      rd_ptr  <= '0;
      chk_vld <= 1'b0;
      nrep    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && accept) begin
        rd_ptr  <= '0;
        chk_vld <= 1'b0;
        nrep    <= '0;
        if (is_setup && !req_err) begin
          valid[req_idx[AW-1:0]] <= 1'b1;
        end
      end else if (state == ST_WALK && advance) begin
        if (report) begin
          nrep <= nrep + RW'(1);
        end
        chk_vld <= more;
        if (more) begin
          rd_ptr <= rd_ptr + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      ack_slot <= req_idx;
      ack_err  <= req_err ? STATUS_ERR : STATUS_OK;
    end
    if (state == ST_WALK && advance && more) begin
      chk_slot <= rd_ptr[AW-1:0];
    end
  end

endmodule

// File: design/periodic_timer_bank_unit.sv
// top level of the periodic timer bank
//
//  channel  | dir | payload
//  ---------+-----+-----------------------------------------------------------
//  s_*      | in  | tuser req_type, tdata slot_index[7:0] period[15:8]
//  m_*      | out | tuser event_kind, tdata slot_out[7:0] status[8], tlast last
//
// start and stop write the slot word and then hand on the acknowledge from the ack
// state; a tick walks one slot per cycle through the slot memory while the output takes its expiries.
// synchronous reset marks every slot disabled through per-slot valid flops.
// a stalled output holds the walk at the slot whose expiry cannot be handed on;
// one finished item and one held expiry can wait while the walk goes on.
`timescale 1ns / 1ps

module periodic_timer_bank_unit #(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // slot_index[7:0], period[15:8]
  input  logic [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // slot_out[7:0], status[8], zero pad
  output logic        m_tuser,   // event_kind
  output logic        m_tlast
);
  import ptb_pkg::*;

  localparam int AW = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;

  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [15:0]   rdata;
  push_t         push;
  logic          push_ready;

  ptb_ram #(
    .WIDTH (16),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  ptb_engine #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .re         (re),
    .raddr      (raddr),
    .rdata      (rdata),
    .push       (push),
    .push_ready (push_ready)
  );

  ptb_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

// File: tb/tb.sv
// testbench for the periodic timer bank: scoreboard with slot predictor, stream drivers, watchdog
`timescale 1ns / 1ps

module tb;
  import ptb_pkg::*;

  localparam int SLOTS = 8;
  localparam int SW = $clog2(SLOTS);
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic       kind;
    logic [7:0] slot;
    logic       status;
    logic       last;
  } timer_event_t;

  class timer_scoreboard;
    logic [7:0] slot_len[SLOTS];
    logic [7:0] slot_ticks[SLOTS];
    timer_event_t due[$];
    int errors;

    function void clear();
      for (int i = 0; i < SLOTS; i++) begin
        slot_len[i] = '0;
        slot_ticks[i] = '0;
      end
      due.delete();
      errors = 0;
    endfunction

    task report(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // work out the items that one accepted request should produce
    task note_request(input logic [1:0] req, input logic [7:0] idx, input logic [7:0] per);
      timer_event_t ev;
      int fired[$];
      logic err;
      case (req)
        REQ_START, REQ_STOP: begin
          err = (idx >= SLOTS);
          if (!err) begin
            slot_ticks[idx[SW-1:0]] = '0;
            slot_len[idx[SW-1:0]] = (req == REQ_START) ? per : 8'd0;
          end
          ev.kind = KIND_ACK;
          ev.slot = idx;
          ev.status = err ? STATUS_ERR : STATUS_OK;
          ev.last = 1'b1;
          due.push_back(ev);
        end
        REQ_TICK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_len[i] != 0) begin
              slot_ticks[i] = slot_ticks[i] + 8'd1;
              if (slot_ticks[i] == slot_len[i]) begin
                slot_ticks[i] = '0;
                if (fired.size() < MAX_RESULTS) fired.push_back(i);
              end
            end
          end
          foreach (fired[k]) begin
            ev.kind = KIND_EXPIRY;
            ev.slot = 8'(fired[k]);
            ev.status = STATUS_OK;
            ev.last = (k == fired.size() - 1);
            due.push_back(ev);
          end
        end
        default: ;
      endcase
    endtask

    task check_event(input logic kind, input logic [7:0] slot, input logic status,
                     input logic last);
      timer_event_t want;
      if (due.size() == 0) begin
        report($sformatf("unexpected item kind %0d slot %0d", kind, slot));
      end else begin
        want = due.pop_front();
        if (kind !== want.kind)
          report($sformatf("event_kind want %0d got %0d", want.kind, kind));
        if (slot !== want.slot)
          report($sformatf("slot_out want %0d got %0d", want.slot, slot));
        if (status !== want.status)
          report($sformatf("status want %0d got %0d (slot %0d)", want.status, status, want.slot));
        if (last !== want.last)
          report($sformatf("last want %0d got %0d (slot %0d)", want.last, last, want.slot));
      end
    endtask

    function int pending();
      return due.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // slot_index[7:0], period[15:8]
  logic [1:0]  s_tuser = REQ_TICK;   // req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;   // slot_out[7:0], status[8], zero pad
  logic        m_tuser;   // event_kind
  logic        m_tlast;

  timer_scoreboard sb = new;
  int items_in = 0;
  int quiet_cycles = 0;
  bit hold_done = 1'b0;

  always #4 clk = ~clk;

  periodic_timer_bank_unit #(.NUM_SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial sb.clear();

  // sample both channels at the edge, plus the stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        sb.note_request(s_tuser, s_tdata[7:0], s_tdata[15:8]);
        items_in++;
      end
      if (m_tvalid && m_tready)
        sb.check_event(m_tuser, m_tdata[7:0], m_tdata[8], m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  function automatic bit calm_stretch();
    return items_in >= 40 && items_in < 70;
  endfunction

  // receiver: random backpressure, one long hold-off while the sender still has requests
  initial begin
    forever begin
      @(posedge clk);
      if (!hold_done && items_in >= 80) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= calm_stretch() || ($urandom_range(0, 99) >= 28);
      end
    end
  end

  task automatic send_req(input logic [1:0] req, input logic [7:0] idx, input logic [7:0] per);
    while (!calm_stretch() && $urandom_range(0, 99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {per, idx};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [7:0] pick_slot();
    return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(0, SLOTS - 1));
  endfunction

  function automatic logic [7:0] pick_period();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(1, 6));
  endfunction

  initial begin
    int r;
    int sent;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: quiet tick with operands set, range errors, unused request code
    send_req(REQ_TICK, 8'hFF, 8'hFF);
    send_req(REQ_START, 8'd0, 8'd1);
    send_req(REQ_START, 8'd7, 8'd255);
    send_req(REQ_START, 8'd8, 8'd5);
    send_req(REQ_START, 8'd255, 8'd0);
    send_req(REQ_STOP, 8'd200, 8'd0);
    send_req(REQ_UNUSED, 8'hAA, 8'h55);
    send_req(REQ_TICK, 8'h00, 8'h00);
    send_req(REQ_START, 8'd3, 8'd0);
    // every slot fires on the same tick
    for (int i = 1; i < SLOTS; i++) send_req(REQ_START, 8'(i), 8'd1);
    send_req(REQ_TICK, 8'h55, 8'hAA);
    send_req(REQ_START, 8'd2, 8'd2);
    send_req(REQ_TICK, 8'd0, 8'd0);
    send_req(REQ_TICK, 8'd0, 8'd0);
    send_req(REQ_STOP, 8'd5, 8'hFF);
    send_req(REQ_STOP, 8'd0, 8'd0);
    send_req(REQ_TICK, 8'd0, 8'd0);

    // random: mostly in-range starts with short periods so ticks keep expiring
    sent = 0;
    while (sent < 70) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_req(REQ_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        sent++;
      end else if (r < 75) begin
        send_req(REQ_START, pick_slot(), pick_period());
        sent++;
      end else if (r < 93) begin
        send_req(REQ_STOP, pick_slot(), 8'($urandom_range(0, 255)));
        sent++;
      end else begin
        send_req(REQ_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (SLOTS + 10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/ptb_pkg.sv
design/ptb_ram.sv
design/ptb_emit.sv
design/ptb_engine.sv
design/periodic_timer_bank_unit.sv
tb/tb.sv
